>>> rtl/core/fdfa_pkg.sv
// Shared types, codes and helpers for the fan duty failsafe arbiter.
package fdfa_pkg;

  localparam logic [6:0] PCT_MAX        = 7'd100;
  localparam int unsigned FAULT_USB_BIT = 0;
  localparam int unsigned FAULT_WD_BIT  = 1;

  localparam logic [15:0] WD_TIMEOUT_RST   = 16'd3000;
  localparam logic [6:0]  DEFAULT_DUTY_RST = 7'd50;
  localparam logic [6:0]  SAFE_DUTY_RST    = 7'd100;
  localparam logic [6:0]  OVR_DUTY_RST     = 7'd100;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned RESQ_DEPTH = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_FAN = 2'd1,
    OP_KICK    = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REPLY_OK       = 2'd0,
    REPLY_BAD_CHAN = 2'd1,
    REPLY_BAD_PCT  = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    SRC_DEFAULT  = 2'd0,
    SRC_HOST     = 2'd1,
    SRC_SAFE     = 2'd2,
    SRC_OVERRIDE = 2'd3
  } src_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WD_TIMEOUT   = 3'd0,
    CFG_DEFAULT_DUTY = 3'd1,
    CFG_SAFE_DUTY    = 3'd2,
    CFG_OVR_ENABLE   = 3'd3,
    CFG_OVR_DUTY     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] fan_channel;
    logic [7:0] duty_request;
    logic       usb_ready;
  } fdfa_in_t;

  typedef struct packed {
    logic [1:0]  reply_code;
    logic [6:0]  duty_one;
    logic [6:0]  duty_two;
    logic        duty_one_changed;
    logic        duty_two_changed;
    logic [1:0]  duty_source;
    logic [15:0] watchdog_left_ms;
    logic [1:0]  fault_bits;
  } fdfa_out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic       is_tick;
    logic       refresh;
    logic       store_duty;
    logic       chan_sel;
    logic [6:0] duty;
    reply_e     reply;
    logic       usb;
  } fdfa_cmd_t;

  function automatic logic [6:0] pct_clamp(input logic [6:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

>>> rtl/core/fan_duty_failsafe_arbiter.sv
// Top level of the two-channel fan duty arbiter with host watchdog.
// Two-entry registered queues sit on each side of a combinational back end.
// Throughput: one transaction per cycle while the result queue is not full; the back
// end executes one command per cycle, bounded by its single state update.
// Reset: asynchronous, active low; queues empty, registers at their defaults,
// timer zero, host not seen, host and output duties at the default duty reset value.
module fan_duty_failsafe_arbiter
  import fdfa_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  input  fdfa_in_t              in_item_i,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output fdfa_out_t             result_o
);

  fdfa_cmd_t front_cmd;
  fdfa_cmd_t cmdq_rdata;
  logic      cmdq_empty;
  logic      cmd_pop;
  logic      res_push;
  logic      resq_full;
  fdfa_out_t res_data;

  fdfa_front u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  fdfa_fifo #(
    .WIDTH ($bits(fdfa_cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmdq_rdata),
    .empty_o (cmdq_empty)
  );

  fdfa_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (!cmdq_empty),
    .cmd_i       (cmdq_rdata),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (resq_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  fdfa_fifo #(
    .WIDTH ($bits(fdfa_out_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .full_o  (resq_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

>>> rtl/core/fdfa_fifo.sv
// Small flop-based queue with show-ahead read.
module fdfa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/fdfa_front.sv
// Front end: decodes and validates an incoming transaction into a command.
module fdfa_front
  import fdfa_pkg::*;
(
  input  fdfa_in_t  item_i,
  output fdfa_cmd_t cmd_o
);

  op_e  op;
  logic chan_ok;
  logic pct_ok;

  assign op      = op_e'(item_i.operation);
  assign chan_ok = (item_i.fan_channel == 8'd1) || (item_i.fan_channel == 8'd2);
  assign pct_ok  = (item_i.duty_request <= {1'b0, PCT_MAX});

  always_comb begin
    cmd_o            = '0;
    cmd_o.reply      = REPLY_OK;
    cmd_o.usb        = item_i.usb_ready;
    cmd_o.chan_sel   = (item_i.fan_channel == 8'd2);
    cmd_o.duty       = item_i.duty_request[6:0];
    case (op)
      OP_TICK: begin
        cmd_o.is_tick = 1'b1;
      end
      OP_SET_FAN: begin
        // channel is checked before the percent
        if (!chan_ok) begin
          cmd_o.reply = REPLY_BAD_CHAN;
        end else if (!pct_ok) begin
          cmd_o.reply = REPLY_BAD_PCT;
        end else begin
          cmd_o.store_duty = 1'b1;
          cmd_o.refresh    = 1'b1;
        end
      end
      OP_KICK: begin
        cmd_o.refresh = 1'b1;
      end
      OP_QUERY: begin
        cmd_o.refresh = 1'b0;
      end
      default: begin
        cmd_o.refresh = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/fdfa_back.sv
// Back end: configuration registers, watchdog timer and duty arbitration.
module fdfa_back
  import fdfa_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  cmd_valid_i,
  input  fdfa_cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output fdfa_out_t             res_o
);

  localparam int unsigned CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [CW-1:0] TMAX = CW'({TIMER_BITS{1'b1}});

  logic [15:0] wd_timeout_q;
  logic [6:0]  default_duty_q, safe_duty_q, ovr_duty_q;
  logic        ovr_enable_q;

  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                  host_seen_q, host_seen_d;
  logic [6:0]            host_duty_q [2];
  logic [6:0]            host_duty_d [2];
  logic [6:0]            out_duty_q [2];
  logic [6:0]            out_duty_d [2];
  src_e                  src_q, src_d;

  logic [CW-1:0] timeout_ext, elapsed_ext, elapsed_nxt_ext, lim;
  logic          expired_nxt;
  logic [6:0]    t1, t2;
  src_e          src_t;
  logic          chg1, chg2;
  logic          fire;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  assign timeout_ext     = CW'(wd_timeout_q);
  assign elapsed_ext     = CW'(elapsed_q);
  assign lim             = (timeout_ext > TMAX) ? TMAX : timeout_ext;
  assign elapsed_nxt_ext = CW'(elapsed_d);
  assign expired_nxt     = (elapsed_nxt_ext >= timeout_ext);

  always_comb begin
    elapsed_d      = elapsed_q;
    host_seen_d    = host_seen_q;
    host_duty_d[0] = host_duty_q[0];
    host_duty_d[1] = host_duty_q[1];
    if (cmd_i.refresh) begin
      elapsed_d   = '0;
      host_seen_d = 1'b1;
    end else if (cmd_i.is_tick && (elapsed_ext < lim)) begin
      elapsed_d = elapsed_q + 1'b1;
    end
    if (cmd_i.store_duty) begin
      host_duty_d[cmd_i.chan_sel] = cmd_i.duty;
    end
  end

  // Arbitration by priority; host_seen does not move on a tick.
  always_comb begin
    if (ovr_enable_q) begin
      t1    = pct_clamp(ovr_duty_q);
      t2    = t1;
      src_t = SRC_OVERRIDE;
    end else if (!cmd_i.usb || (host_seen_q && expired_nxt)) begin
      t1    = pct_clamp(safe_duty_q);
      t2    = t1;
      src_t = SRC_SAFE;
    end else if (host_seen_q) begin
      t1    = host_duty_q[0];
      t2    = host_duty_q[1];
      src_t = SRC_HOST;
    end else begin
      t1    = pct_clamp(default_duty_q);
      t2    = t1;
      src_t = SRC_DEFAULT;
    end
  end

  always_comb begin
    out_duty_d[0] = out_duty_q[0];
    out_duty_d[1] = out_duty_q[1];
    src_d         = src_q;
    chg1          = 1'b0;
    chg2          = 1'b0;
    if (cmd_i.is_tick) begin
      chg1          = (t1 != out_duty_q[0]);
      chg2          = (t2 != out_duty_q[1]);
      out_duty_d[0] = t1;
      out_duty_d[1] = t2;
      src_d         = src_t;
    end
  end

  always_comb begin
    res_o                  = '0;
    res_o.reply_code       = cmd_i.reply;
    res_o.duty_one         = out_duty_d[0];
    res_o.duty_two         = out_duty_d[1];
    res_o.duty_one_changed = chg1;
    res_o.duty_two_changed = chg2;
    res_o.duty_source      = src_d;
    res_o.watchdog_left_ms = expired_nxt ? 16'd0 : 16'(timeout_ext - elapsed_nxt_ext);
    res_o.fault_bits[FAULT_USB_BIT] = !cmd_i.usb;
    res_o.fault_bits[FAULT_WD_BIT]  = host_seen_d && expired_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_timeout_q   <= WD_TIMEOUT_RST;
      default_duty_q <= DEFAULT_DUTY_RST;
      safe_duty_q    <= SAFE_DUTY_RST;
      ovr_enable_q   <= 1'b0;
      ovr_duty_q     <= OVR_DUTY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WD_TIMEOUT:   wd_timeout_q   <= cfg_wdata_i;
        CFG_DEFAULT_DUTY: default_duty_q <= cfg_wdata_i[6:0];
        CFG_SAFE_DUTY:    safe_duty_q    <= cfg_wdata_i[6:0];
        CFG_OVR_ENABLE:   ovr_enable_q   <= cfg_wdata_i[0];
        CFG_OVR_DUTY:     ovr_duty_q     <= cfg_wdata_i[6:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q      <= '0;
      host_seen_q    <= 1'b0;
      host_duty_q[0] <= DEFAULT_DUTY_RST;
      host_duty_q[1] <= DEFAULT_DUTY_RST;
      out_duty_q[0]  <= DEFAULT_DUTY_RST;
      out_duty_q[1]  <= DEFAULT_DUTY_RST;
      src_q          <= SRC_DEFAULT;
    end else if (fire) begin
      elapsed_q      <= elapsed_d;
      host_seen_q    <= host_seen_d;
      host_duty_q[0] <= host_duty_d[0];
      host_duty_q[1] <= host_duty_d[1];
      out_duty_q[0]  <= out_duty_d[0];
      out_duty_q[1]  <= out_duty_d[1];
      src_q          <= src_d;
    end
  end

endmodule

>>> rtl/core/fdfa_checker.sv
// Port-level checks for the fan duty arbiter, bound to the top level.
module fdfa_checker
  import fdfa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  push,
  input fdfa_in_t              in_item_i,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input fdfa_out_t             result_o
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed or vanished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((result_o.duty_one <= PCT_MAX) && (result_o.duty_two <= PCT_MAX)))
    else $error("output duty above 100 percent");

  // only ticks change duties, and ticks always reply ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.duty_one_changed || result_o.duty_two_changed))
      |-> (result_o.reply_code == REPLY_OK))
    else $error("duty change reported with error reply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.fault_bits[FAULT_WD_BIT]) |-> (result_o.watchdog_left_ms == 16'd0))
    else $error("watchdog fault with time left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.duty_source == SRC_SAFE)
      && !result_o.duty_one_changed && !result_o.duty_two_changed
      && (result_o.reply_code != REPLY_OK)) |-> (result_o.duty_one == result_o.duty_two))
    else $error("safe source with unequal duties");

endmodule

bind fan_duty_failsafe_arbiter fdfa_checker u_fdfa_checker (.*);

>>> sim/fdfa_status_checker.sv
// Checker for the fan duty arbiter: tracks accepted transactions, predicts status, compares.
module fdfa_status_checker
  import fdfa_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  input  logic                  full,
  input  fdfa_in_t              in_item_i,
  input  logic                  empty,
  input  logic                  pop,
  input  fdfa_out_t             result_o,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  // Register mirror
  logic [15:0] wd_timeout_q;
  logic [6:0]  dflt_duty_q;
  logic [6:0]  safe_duty_q;
  logic        ovr_en_q;
  logic [6:0]  ovr_duty_q;

  // Arbiter state mirror
  int unsigned elapsed;
  logic        host_seen;
  logic [6:0]  host_duty [2];
  logic [6:0]  out_duty [2];
  src_e        cur_src;

  fdfa_out_t status_due [$];
  int        mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = status_due.size();

  function automatic logic [6:0] cap_pct(input logic [6:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

  function automatic logic wd_over();
    return elapsed >= 32'(wd_timeout_q);
  endfunction

  // Advance the mirror by one transaction and return the status it reports.
  function automatic fdfa_out_t arbitrate(input fdfa_in_t it);
    fdfa_out_t   st;
    logic [6:0]  want_one;
    logic [6:0]  want_two;
    int unsigned lim;
    st = '0;
    case (op_e'(it.operation))
      OP_TICK: begin
        lim = 32'(wd_timeout_q);
        if (lim > TIMER_MAX) lim = TIMER_MAX;
        if (elapsed < lim) elapsed = elapsed + 1;
        if (ovr_en_q) begin
          want_one = cap_pct(ovr_duty_q);
          want_two = want_one;
          cur_src  = SRC_OVERRIDE;
        end else if (!it.usb_ready || (host_seen && wd_over())) begin
          want_one = cap_pct(safe_duty_q);
          want_two = want_one;
          cur_src  = SRC_SAFE;
        end else if (host_seen) begin
          want_one = host_duty[0];
          want_two = host_duty[1];
          cur_src  = SRC_HOST;
        end else begin
          want_one = cap_pct(dflt_duty_q);
          want_two = want_one;
          cur_src  = SRC_DEFAULT;
        end
        st.duty_one_changed = (want_one != out_duty[0]);
        st.duty_two_changed = (want_two != out_duty[1]);
        out_duty[0] = want_one;
        out_duty[1] = want_two;
      end
      OP_SET_FAN: begin
        // Channel is checked before percent
        if (it.fan_channel != 8'd1 && it.fan_channel != 8'd2) begin
          st.reply_code = REPLY_BAD_CHAN;
        end else if (it.duty_request > 8'(PCT_MAX)) begin
          st.reply_code = REPLY_BAD_PCT;
        end else begin
          host_duty[it.fan_channel == 8'd2] = it.duty_request[6:0];
          elapsed   = 0;
          host_seen = 1'b1;
        end
      end
      OP_KICK: begin
        elapsed   = 0;
        host_seen = 1'b1;
      end
      default: ;
    endcase
    st.duty_one    = out_duty[0];
    st.duty_two    = out_duty[1];
    st.duty_source = cur_src;
    st.watchdog_left_ms = wd_over() ? 16'd0 : 16'(32'(wd_timeout_q) - elapsed);
    st.fault_bits[FAULT_USB_BIT] = !it.usb_ready;
    st.fault_bits[FAULT_WD_BIT]  = host_seen && wd_over();
    return st;
  endfunction

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fdfa_out_t want;
    if (!rst_ni) begin
      wd_timeout_q = WD_TIMEOUT_RST;
      dflt_duty_q  = DEFAULT_DUTY_RST;
      safe_duty_q  = SAFE_DUTY_RST;
      ovr_en_q     = 1'b0;
      ovr_duty_q   = OVR_DUTY_RST;
      elapsed      = 0;
      host_seen    = 1'b0;
      host_duty[0] = DEFAULT_DUTY_RST;
      host_duty[1] = DEFAULT_DUTY_RST;
      out_duty[0]  = DEFAULT_DUTY_RST;
      out_duty[1]  = DEFAULT_DUTY_RST;
      cur_src      = SRC_DEFAULT;
      status_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WD_TIMEOUT:   wd_timeout_q = cfg_wdata_i[15:0];
          CFG_DEFAULT_DUTY: dflt_duty_q  = cfg_wdata_i[6:0];
          CFG_SAFE_DUTY:    safe_duty_q  = cfg_wdata_i[6:0];
          CFG_OVR_ENABLE:   ovr_en_q     = cfg_wdata_i[0];
          CFG_OVR_DUTY:     ovr_duty_q   = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      // Retire the oldest status before queuing the new one
      if (pop && !empty) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: no transaction waiting, expected none actual %h", $time, result_o);
        end else begin
          want = status_due.pop_front();
          flag_field("reply_code", want.reply_code, result_o.reply_code);
          flag_field("duty_one", want.duty_one, result_o.duty_one);
          flag_field("duty_two", want.duty_two, result_o.duty_two);
          flag_field("duty_one_changed", want.duty_one_changed, result_o.duty_one_changed);
          flag_field("duty_two_changed", want.duty_two_changed, result_o.duty_two_changed);
          flag_field("duty_source", want.duty_source, result_o.duty_source);
          flag_field("watchdog_left_ms", want.watchdog_left_ms, result_o.watchdog_left_ms);
          flag_field("fault_bits", want.fault_bits, result_o.fault_bits);
        end
      end
      if (push && !full) status_due.push_back(arbitrate(in_item_i));
    end
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the fan duty arbiter: clock, reset, stimulus and verdict.
module tb_top;
  import fdfa_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  push;
  fdfa_in_t              in_item;
  logic                  full;
  logic                  empty;
  logic                  pop;
  fdfa_out_t             status;
  int                    fail_count;
  int                    pending;

  bit calm;
  bit hold_req;

  always #2 clk_i = ~clk_i;

  fan_duty_failsafe_arbiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .in_item_i   (in_item),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .result_o    (status)
  );

  fdfa_status_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item),
    .empty        (empty),
    .pop          (pop),
    .result_o     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fdfa_in_t mk(input op_e op, input logic [7:0] ch, input logic [7:0] pct,
                                  input logic usb);
    fdfa_in_t it;
    it.operation    = op;
    it.fan_channel  = ch;
    it.duty_request = pct;
    it.usb_ready    = usb;
    return it;
  endfunction

  // Mostly well-formed host traffic; host_pct sets how busy the host is.
  function automatic fdfa_in_t rand_item(input int host_pct);
    fdfa_in_t it;
    int r;
    it.fan_channel  = 8'($urandom);
    it.duty_request = 8'($urandom);
    it.usb_ready    = ($urandom_range(0, 99) < 85);
    r = $urandom_range(0, 99);
    if (r < host_pct) begin
      it.operation = OP_SET_FAN;
      if ($urandom_range(0, 9) < 8) begin
        it.fan_channel  = 8'($urandom_range(1, 2));
        it.duty_request = 8'($urandom_range(0, 100));
      end
    end else if (r < host_pct + host_pct / 3 + 1) begin
      it.operation = OP_KICK;
    end else if (r < 80) begin
      it.operation = OP_TICK;
    end else begin
      it.operation = OP_QUERY;
    end
    return it;
  endfunction

  function automatic logic [15:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(1, 6));
    if (r < 60) return 16'($urandom_range(7, 40));
    if (r < 75) return 16'd0;
    if (r < 90) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  task automatic offer(input fdfa_in_t it);
    int gap;
    gap = idle_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
  endtask

  // Drain every outstanding transaction before touching registers.
  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_duty_reg(input cfg_idx_e idx, input logic [6:0] val);
    set_reg(idx, {9'($urandom), val});
  endtask

  task automatic load_setting(input logic [15:0] tmo, input logic [6:0] dflt,
                              input logic [6:0] safe, input logic en, input logic [6:0] ovr);
    set_reg(CFG_WD_TIMEOUT, tmo);
    set_duty_reg(CFG_DEFAULT_DUTY, dflt);
    set_duty_reg(CFG_SAFE_DUTY, safe);
    set_reg(CFG_OVR_ENABLE, {15'($urandom), en});
    set_duty_reg(CFG_OVR_DUTY, ovr);
  endtask

  // Receiver: random pop bursts and gaps, plus one long hold-off on request.
  initial begin
    int burst;
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (200) @(posedge clk_i);
      end
      burst = $urandom_range(1, 24);
      pop <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = idle_len();
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    #2000000;
    $display("fan_duty_failsafe_arbiter verification failed");
    $finish;
  end

  initial begin
    int host_pct;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    push      <= 1'b0;
    in_item   <= '0;
    pop       <= 1'b0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: default and safe sources before the host shows up
    offer(mk(OP_QUERY, 8'hFF, 8'hFF, 1'b1));
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b0));
    settle();
    set_duty_reg(CFG_DEFAULT_DUTY, 7'd127);
    set_duty_reg(CFG_SAFE_DUTY, 7'd0);
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b0));
    // Rejected commands must not mark the host as seen
    offer(mk(OP_SET_FAN, 8'd0, 8'd0, 1'b1));
    offer(mk(OP_SET_FAN, 8'd255, 8'd255, 1'b1));
    offer(mk(OP_SET_FAN, 8'd3, 8'd50, 1'b1));
    offer(mk(OP_SET_FAN, 8'd1, 8'd101, 1'b1));
    offer(mk(OP_SET_FAN, 8'd2, 8'd255, 1'b1));
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_SET_FAN, 8'd1, 8'd0, 1'b1));
    offer(mk(OP_SET_FAN, 8'd2, 8'd100, 1'b1));
    offer(mk(OP_TICK, 8'hFF, 8'hFF, 1'b1));
    settle();
    set_reg(CFG_WD_TIMEOUT, 16'd2);
    set_duty_reg(CFG_OVR_DUTY, 7'd127);
    // Run the watchdog out and past saturation, then recover with a kick
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_QUERY, 8'h00, 8'h00, 1'b0));
    offer(mk(OP_KICK, 8'hAA, 8'h55, 1'b1));
    offer(mk(OP_TICK, 8'h55, 8'hAA, 1'b1));
    settle();
    set_reg(CFG_OVR_ENABLE, 16'd1);
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    settle();
    set_reg(CFG_WD_TIMEOUT, 16'd0);
    set_duty_reg(CFG_OVR_DUTY, 7'd0);
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b0));
    settle();
    set_reg(CFG_OVR_ENABLE, 16'd0);
    // Zero timeout: expired even right after a kick
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));
    offer(mk(OP_KICK, 8'h00, 8'h00, 1'b0));
    settle();
    set_reg(CFG_WD_TIMEOUT, 16'hFFFF);
    offer(mk(OP_TICK, 8'h00, 8'h00, 1'b1));

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 0)
        load_setting(16'hFFFF, 7'd0, 7'd0, 1'b0, 7'd0);
      else if (ph == 1)
        load_setting(16'd1, 7'd100, 7'd100, 1'b1, 7'd100);
      else
        load_setting(pick_timeout(), 7'($urandom), 7'($urandom),
                     ($urandom_range(0, 3) == 0), 7'($urandom));
      calm     = (ph == 2 || ph == 3 || ph == 5);
      host_pct = ($urandom_range(0, 2) == 0) ? 3 : 25;
      // Stall the receiver while the sender keeps offering
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 88; n++) offer(rand_item(host_pct));
    end

    calm = 1'b0;
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("fan_duty_failsafe_arbiter verification clean");
    else
      $display("fan_duty_failsafe_arbiter verification failed");
    $finish;
  end

endmodule
